// ===== hdl/q2e_pkg.sv =====
// Shared types, constants and helpers for the quaternion to Euler angle unit.
// No dependencies.
package q2e_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;

    localparam int TW        = 35;
    localparam int CW        = 38;
    localparam int RW        = 61;
    localparam int ROOT_W    = 31;
    localparam int SQ_STAGES = 31;
    localparam int LANES     = 3;

    localparam int LANE_PITCH = 0;
    localparam int LANE_ROLL  = 1;
    localparam int LANE_YAW   = 2;

    localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
    localparam logic signed [15:0] PITCH_MIN = -16'sd16384;

    typedef logic signed [TW-1:0]   term_t;
    typedef logic signed [CW-1:0]   cval_t;
    typedef logic [ANGLE_BITS-1:0]  angle_t;

    typedef struct packed {
        term_t roll_s;
        term_t roll_c;
        term_t yaw_s;
        term_t yaw_c;
        term_t pit_s;
        logic  clamp;
    } terms_t;

    typedef struct packed {
        logic   zero;
        cval_t  x;
        cval_t  y;
        angle_t acc;
    } lane_t;

    typedef struct packed {
        logic clamp;
        logic pos;
    } psb_t;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    function automatic angle_t tab_entry(input int i);
        logic [63:0] t;
        t = 64'(ATAN_TAB[i % 32]);
        if (ANGLE_BITS == 32) begin
            return angle_t'(t);
        end
        return angle_t'((t + (64'(1) << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS));
    endfunction

    function automatic logic [15:0] to_out16(input angle_t a);
        logic [63:0] a64;
        a64 = 64'(a);
        if (ANGLE_BITS > 16) begin
            return 16'((a64 + (64'(1) << (ANGLE_BITS - 17))) >> (ANGLE_BITS - 16));
        end
        return 16'(a64 << (16 - ANGLE_BITS));
    endfunction

endpackage

// ===== hdl/q2e_terms.sv =====
// Front end: quaternion products, sine/cosine terms and pitch cosine radicand.
// Depends on q2e_pkg.
module q2e_terms (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [15:0]        in_w,
    input  logic signed [15:0]        in_x,
    input  logic signed [15:0]        in_y,
    input  logic signed [15:0]        in_z,
    output logic                      out_valid,
    output logic [q2e_pkg::RW-1:0]    out_rem,
    output q2e_pkg::terms_t           out_terms
);
    import q2e_pkg::*;

    localparam term_t ONE_Q30 = term_t'(1) <<< 30;

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;
    logic v1_reg, v2_reg, v3_reg;
    terms_t t2_reg, t2_next, t3_reg;
    logic [RW-1:0] rem_reg;
    term_t pabs;
    logic [59:0] sq;

    always_comb begin
        t2_next.roll_s = (TW'(wx_reg) + TW'(yz_reg)) <<< 1;
        t2_next.roll_c = ONE_Q30 - ((TW'(xx_reg) + TW'(yy_reg)) <<< 1);
        t2_next.yaw_s  = (TW'(wz_reg) + TW'(xy_reg)) <<< 1;
        t2_next.yaw_c  = ONE_Q30 - ((TW'(yy_reg) + TW'(zz_reg)) <<< 1);
        t2_next.pit_s  = (TW'(wy_reg) - TW'(zx_reg)) <<< 1;
        t2_next.clamp  = (t2_next.pit_s >= ONE_Q30) || (t2_next.pit_s <= -ONE_Q30);
    end

    assign pabs = t2_reg.pit_s[TW-1] ? -t2_reg.pit_s : t2_reg.pit_s;
    assign sq   = pabs[29:0] * pabs[29:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            wx_reg  <= in_w * in_x;
            yz_reg  <= in_y * in_z;
            xx_reg  <= in_x * in_x;
            yy_reg  <= in_y * in_y;
            wz_reg  <= in_w * in_z;
            xy_reg  <= in_x * in_y;
            zz_reg  <= in_z * in_z;
            wy_reg  <= in_w * in_y;
            zx_reg  <= in_z * in_x;
            t2_reg  <= t2_next;
            t3_reg  <= t2_reg;
            rem_reg <= (RW'(1) << 60) - RW'(sq);
        end
    end

    assign out_valid = v3_reg;
    assign out_rem   = rem_reg;
    assign out_terms = t3_reg;
endmodule

// ===== hdl/q2e_isqrt.sv =====
// Pipelined floor square root, one result bit per stage; carries the terms along.
// Depends on q2e_pkg.
module q2e_isqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [q2e_pkg::RW-1:0]     in_rem,
    input  q2e_pkg::terms_t            in_terms,
    output logic                       out_valid,
    output logic [q2e_pkg::ROOT_W-1:0] out_root,
    output q2e_pkg::terms_t            out_terms
);
    import q2e_pkg::*;

    logic          vld_reg [SQ_STAGES];
    logic [RW-1:0] v_reg   [SQ_STAGES];
    logic [RW-1:0] r_reg   [SQ_STAGES];
    terms_t        t_reg   [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
        localparam logic [RW-1:0] BIT = RW'(1) << (RW - 1 - 2 * k);
        logic          vld_in;
        logic [RW-1:0] v_in, r_in, sum;
        terms_t        t_in;

        if (k == 0) begin : g_first
            assign vld_in = in_valid;
            assign v_in   = in_rem;
            assign r_in   = '0;
            assign t_in   = in_terms;
        end else begin : g_rest
            assign vld_in = vld_reg[k-1];
            assign v_in   = v_reg[k-1];
            assign r_in   = r_reg[k-1];
            assign t_in   = t_reg[k-1];
        end

        assign sum = r_in + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
            if (en) begin
                if (v_in >= sum) begin
                    v_reg[k] <= v_in - sum;
                    r_reg[k] <= (r_in >> 1) + BIT;
                end else begin
                    v_reg[k] <= v_in;
                    r_reg[k] <= r_in >> 1;
                end
                t_reg[k] <= t_in;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign out_root  = r_reg[SQ_STAGES-1][ROOT_W-1:0];
    assign out_terms = t_reg[SQ_STAGES-1];
endmodule

// ===== hdl/q2e_cordic.sv =====
// Three-lane vectoring CORDIC pipeline (pitch, roll, yaw), one rotation per stage.
// Depends on q2e_pkg.
module q2e_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  q2e_pkg::cval_t        in_y [q2e_pkg::LANES],
    input  q2e_pkg::cval_t        in_x [q2e_pkg::LANES],
    input  q2e_pkg::psb_t         in_psb,
    output logic                  out_valid,
    output q2e_pkg::angle_t       out_angle [q2e_pkg::LANES],
    output q2e_pkg::psb_t         out_psb
);
    import q2e_pkg::*;

    logic  vld_reg  [CORDIC_STAGES+1];
    lane_t lane_reg [CORDIC_STAGES+1][LANES];
    psb_t  psb_reg  [CORDIC_STAGES+1];

    for (genvar l = 0; l < LANES; l++) begin : g_pre
        lane_t lane_next;
        always_comb begin
            lane_next.zero = (in_x[l] == '0) && (in_y[l] == '0);
            if (in_x[l][CW-1]) begin
                lane_next.x   = -in_x[l];
                lane_next.y   = -in_y[l];
                lane_next.acc = angle_t'(1) << (ANGLE_BITS - 1);
            end else begin
                lane_next.x   = in_x[l];
                lane_next.y   = in_y[l];
                lane_next.acc = '0;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                lane_reg[0][l] <= lane_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            psb_reg[0] <= in_psb;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
        localparam angle_t ATAN_I = tab_entry(i);
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            lane_t cur, lane_next;
            assign cur = lane_reg[i][l];
            always_comb begin
                lane_next.zero = cur.zero;
                if (!cur.y[CW-1]) begin
                    lane_next.x   = cur.x + (cur.y >>> i);
                    lane_next.y   = cur.y - (cur.x >>> i);
                    lane_next.acc = cur.acc + ATAN_I;
                end else begin
                    lane_next.x   = cur.x - (cur.y >>> i);
                    lane_next.y   = cur.y + (cur.x >>> i);
                    lane_next.acc = cur.acc - ATAN_I;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    lane_reg[i+1][l] <= lane_next;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                psb_reg[i+1] <= psb_reg[i];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_angle[l] = lane_reg[CORDIC_STAGES][l].zero ? '0
                                                              : lane_reg[CORDIC_STAGES][l].acc;
    end

    assign out_valid = vld_reg[CORDIC_STAGES];
    assign out_psb   = psb_reg[CORDIC_STAGES];
endmodule

// ===== hdl/quaternion_to_euler_angles_unit.sv =====
// Quaternion (Q1.15) to roll/pitch/yaw binary angles, top level.
// Depends on q2e_pkg, q2e_terms, q2e_isqrt, q2e_cordic.
//
// Takes one quaternion word per cycle while the output is not stalled and returns one
// angle word per word through 3 product/term stages, 31 square root stages for the
// pitch cosine, 17 CORDIC stages and the output register. A stall at m_ready holds
// the whole pipeline; nothing is dropped. angle_x is pitch, angle_y roll,
// angle_z yaw, all with 32768 = pi; pitch saturates at +/-16384, with
// pitch_clamped set when the pitch sine term reaches +/-1.
module quaternion_to_euler_angles_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_angle_x,
    output logic signed [15:0] m_angle_y,
    output logic signed [15:0] m_angle_z,
    output logic               m_pitch_clamped
);
    import q2e_pkg::*;

    logic en;
    logic t_valid, q_valid, c_valid;
    logic [RW-1:0] t_rem;
    terms_t t_terms, q_terms;
    logic [ROOT_W-1:0] q_root;
    cval_t c_y [LANES];
    cval_t c_x [LANES];
    psb_t  c_psb, o_psb;
    angle_t o_angle [LANES];

    logic m_valid_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, ax_next, pv;
    logic clamp_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    q2e_terms u_terms (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_w      (s_quat_w),
        .in_x      (s_quat_x),
        .in_y      (s_quat_y),
        .in_z      (s_quat_z),
        .out_valid (t_valid),
        .out_rem   (t_rem),
        .out_terms (t_terms)
    );

    q2e_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t_valid),
        .in_rem    (t_rem),
        .in_terms  (t_terms),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_terms (q_terms)
    );

    assign c_y[LANE_PITCH] = CW'(q_terms.pit_s);
    assign c_x[LANE_PITCH] = CW'(q_root);
    assign c_y[LANE_ROLL]  = CW'(q_terms.roll_s);
    assign c_x[LANE_ROLL]  = CW'(q_terms.roll_c);
    assign c_y[LANE_YAW]   = CW'(q_terms.yaw_s);
    assign c_x[LANE_YAW]   = CW'(q_terms.yaw_c);
    assign c_psb.clamp     = q_terms.clamp;
    assign c_psb.pos       = (q_terms.pit_s > 0);

    q2e_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_y      (c_y),
        .in_x      (c_x),
        .in_psb    (c_psb),
        .out_valid (c_valid),
        .out_angle (o_angle),
        .out_psb   (o_psb)
    );

    always_comb begin
        pv = signed'(to_out16(o_angle[LANE_PITCH]));
        if (o_psb.clamp) begin
            ax_next = o_psb.pos ? PITCH_MAX : PITCH_MIN;
        end else if (pv > PITCH_MAX) begin
            ax_next = PITCH_MAX;
        end else if (pv < PITCH_MIN) begin
            ax_next = PITCH_MIN;
        end else begin
            ax_next = pv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c_valid;
        end
        if (en) begin
            ax_reg    <= ax_next;
            ay_reg    <= signed'(to_out16(o_angle[LANE_ROLL]));
            az_reg    <= signed'(to_out16(o_angle[LANE_YAW]));
            clamp_reg <= o_psb.clamp;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_angle_x       = ax_reg;
    assign m_angle_y       = ay_reg;
    assign m_angle_z       = az_reg;
    assign m_pitch_clamped = clamp_reg;
endmodule

// ===== hdl/q2e_checker.sv =====
// Port-level checks for the quaternion to Euler angle unit, bound to the top level.
// Depends on quaternion_to_euler_angles_unit.
module q2e_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_angle_x,
    input logic signed [15:0] m_angle_y,
    input logic               m_pitch_clamped
);
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_x <= 16'sd16384) && (m_angle_x >= -16'sd16384))
        else $error("pitch out of range");

    a_clamp_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pitch_clamped |-> (m_angle_x == 16'sd16384) || (m_angle_x == -16'sd16384))
        else $error("clamped pitch not saturated");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_angle_y))
        else $error("stalled output word changed");
endmodule

bind quaternion_to_euler_angles_unit q2e_checker u_q2e_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_angle_x       (m_angle_x),
    .m_angle_y       (m_angle_y),
    .m_pitch_clamped (m_pitch_clamped)
);

// ===== verif/quaternion_to_euler_angles_unit_test.sv =====
// Testbench for quaternion_to_euler_angles_unit: drives quaternion words, predicts
// pitch/roll/yaw with a bit-exact CORDIC model and checks every angle word in order.
// Depends on q2e_pkg and the unit's RTL.
module quaternion_to_euler_angles_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import q2e_pkg::*;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic               clamp;
    } euler_t;

    class euler_board;
        euler_t pending[$];
        int     errors;

        function longint asr(longint v, int s);
            return v >>> s;
        endfunction

        function logic [63:0] tab_val(int i);
            logic [63:0] t;
            int sh;
            t = 64'(ATAN_TAB[i % 32]);
            sh = 32 - ANGLE_BITS;
            if (sh == 0) return t;
            return (t + (64'(1) << (sh - 1))) >> sh;
        endfunction

        function logic [63:0] vec_angle(longint y, longint x);
            logic [63:0] acc;
            longint xs, ys;
            int n;
            acc = 0;
            n = CORDIC_STAGES > 32 ? 32 : CORDIC_STAGES;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                acc = 64'(1) << (ANGLE_BITS - 1);
            end
            for (int i = 0; i < n; i++) begin
                xs = asr(x, i);
                ys = asr(y, i);
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    acc += tab_val(i);
                end else begin
                    x = x - ys;
                    y = y + xs;
                    acc -= tab_val(i);
                end
            end
            return acc & ((64'(1) << ANGLE_BITS) - 1);
        endfunction

        function logic [15:0] out16(logic [63:0] a);
            int sh;
            if (ANGLE_BITS > 16) begin
                sh = ANGLE_BITS - 16;
                return 16'((a + (64'(1) << (sh - 1))) >> sh);
            end
            return 16'(a << (16 - ANGLE_BITS));
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'(1) << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                                logic signed [15:0] qy, logic signed [15:0] qz);
            longint w, x, y, z, one, rs, rc, ys, yc, ps, c, v;
            euler_t e;
            w = qw; x = qx; y = qy; z = qz;
            one = longint'(1) << 30;
            rs = 2 * (w * x + y * z);
            rc = one - 2 * (x * x + y * y);
            ys = 2 * (w * z + x * y);
            yc = one - 2 * (y * y + z * z);
            ps = 2 * (w * y - z * x);
            e.clamp = 0;
            if (ps >= one || ps <= -one) begin
                e.clamp = 1;
                e.ax = ps > 0 ? PITCH_MAX : PITCH_MIN;
            end else begin
                c = longint'(floor_sqrt((64'(1) << 60) - 64'(ps * ps)));
                v = longint'(signed'(out16(vec_angle(ps, c))));
                if (v > 16384) v = 16384;
                if (v < -16384) v = -16384;
                e.ax = 16'(v);
            end
            e.ay = out16(vec_angle(rs, rc));
            e.az = out16(vec_angle(ys, yc));
            pending.push_back(e);
        endfunction

        function void check_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                                   logic signed [15:0] az, logic clamp);
            euler_t e;
            if (pending.size() == 0) begin
                $error("angle word with no quaternion outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ax !== e.ax) begin
                $error("angle_x expected %0d actual %0d", e.ax, ax);
                errors++;
            end
            if (ay !== e.ay) begin
                $error("angle_y expected %0d actual %0d", e.ay, ay);
                errors++;
            end
            if (az !== e.az) begin
                $error("angle_z expected %0d actual %0d", e.az, az);
                errors++;
            end
            if (clamp !== e.clamp) begin
                $error("pitch_clamped expected %0b actual %0b", e.clamp, clamp);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [15:0] s_quat_w = 0, s_quat_x = 0, s_quat_y = 0, s_quat_z = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [15:0] m_angle_x, m_angle_y, m_angle_z;
    logic               m_pitch_clamped;

    euler_board board = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 0;

    quaternion_to_euler_angles_unit DUT (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_angles(m_angle_x, m_angle_y, m_angle_z, m_pitch_clamped);
        if (aresetn && s_valid && s_ready)
            board.note_quat(s_quat_w, s_quat_x, s_quat_y, s_quat_z);
    end

    always @(posedge aclk) begin
        if (!aresetn || recv_hold)
            m_ready <= 0;
        else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z);
        int idle;
        idle = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            idle++;
        if (idle > 0) begin
            s_valid <= 0;
            repeat (idle) @(posedge aclk);
        end
        s_valid  <= 1;
        s_quat_w <= w;
        s_quat_x <= x;
        s_quat_y <= y;
        s_quat_z <= z;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 46341) - 23170);
            default: return 16'($urandom_range(0, 16384) - 8192);
        endcase
    endfunction

    task automatic send_random(int count);
        int m;
        for (int i = 0; i < count; i++) begin
            m = $urandom_range(2);
            // unit-ish quaternions for a little under half the words, full-range noise for the rest
            if ($urandom_range(9) < 7 && m != 0) begin
                case ($urandom_range(3))
                    0: send_quat(16'h7FFF, rand_comp(2), rand_comp(2), rand_comp(2));
                    1: send_quat(rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1));
                    2: send_quat(16'd23170, rand_comp(2), 16'd23170, rand_comp(2));
                    default: send_quat(rand_comp(2), 16'd23170, rand_comp(2), 16'hA57E);
                endcase
            end else begin
                send_quat(rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_quat(16'h7FFF, 0, 0, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(0, 0, 0, 0);
        send_quat(16'd23170, 0, 16'd23170, 0);
        send_quat(16'd23170, 0, 16'hA57E, 0);
        send_quat(16'd23170, 16'd23170, 0, 0);
        send_quat(0, 16'h7FFF, 0, 0);
        send_quat(0, 0, 16'h7FFF, 0);
        send_quat(0, 0, 0, 16'h7FFF);
        send_quat(16'd23170, 16'hA57E, 0, 0);
        send_quat(0, 16'h8000, 0, 16'h7FFF);
        send_quat(16'h7FFF, 0, 16'h7FFF, 0);
        send_quat(16'd23171, 0, 16'd23171, 0);
        send_quat(16'h8000, 0, 16'h7FFF, 0);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
        send_quat(16'h7FFF, 0, 0, 16'h8000);
        drain();

        send_idle_pct = 21;
        recv_idle_pct = 55;
        send_random(380);
        send_idle_pct = 55;
        recv_idle_pct = 21;
        send_random(380);

        // long receiver stall so the pipeline fills and backpressures
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                recv_hold = 1;
                repeat (200) @(posedge aclk);
                recv_hold = 0;
            end
            send_random(120);
        join
        drain();
        send_random(270);
        drain();
        repeat (80) @(posedge aclk);

        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/q2e_pkg.sv
hdl/q2e_terms.sv
hdl/q2e_isqrt.sv
hdl/q2e_cordic.sv
hdl/quaternion_to_euler_angles_unit.sv
hdl/q2e_checker.sv
verif/quaternion_to_euler_angles_unit_test.sv
